// ----- rtl/hsv2rgb_pkg.sv -----
// Shared types, item structs and the perceptual dim-curve table for the HSV to RGB pipeline.
`default_nettype none

package hsv2rgb_pkg;

    // Hue sector, one per 60 degrees.
    typedef enum logic [2:0] {
        SEC_RED_YELLOW    = 3'd0,
        SEC_YELLOW_GREEN  = 3'd1,
        SEC_GREEN_CYAN    = 3'd2,
        SEC_CYAN_BLUE     = 3'd3,
        SEC_BLUE_MAGENTA  = 3'd4,
        SEC_MAGENTA_RED   = 3'd5
    } sector_t;

    typedef struct packed {
        logic [6:0] led_index;
        logic [8:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } pixel_t;

    typedef struct packed {
        logic [6:0]  led_number;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [23:0] grb_word;
    } result_t;

    // After the table look-ups and the sector split.
    typedef struct packed {
        logic [6:0] led_index;
        sector_t    sector;
        logic       grey;
        logic [5:0] frac;
        logic [7:0] val;
        logic [7:0] dim_sat;
    } s1_t;

    // After the base level multiply.
    typedef struct packed {
        logic [6:0] led_index;
        sector_t    sector;
        logic       grey;
        logic [5:0] frac;
        logic [7:0] val;
        logic [7:0] lo;
    } s2_t;

    // After the span times fraction multiply.
    typedef struct packed {
        logic [6:0]  led_index;
        sector_t     sector;
        logic        grey;
        logic [13:0] prod;
        logic [7:0]  val;
        logic [7:0]  lo;
    } s3_t;

    // After the divide by 60 and the base add.
    typedef struct packed {
        logic [6:0] led_index;
        sector_t    sector;
        logic       grey;
        logic [7:0] ramp;
        logic [7:0] val;
        logic [7:0] lo;
    } s4_t;

    localparam logic [8:0] HUE_FULL  = 9'd360;
    localparam logic [5:0] SECTOR_SPAN = 6'd60;
    // Reciprocal of 15 scaled by 2^16, exact for dividends below 4681.
    localparam logic [12:0] RECIP_15 = 13'd4370;

    localparam logic [7:0] PERC_LUT [256] = '{
        8'd0, 8'd1, 8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2,
        8'd2, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3,
        8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd4,
        8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4,
        8'd4, 8'd4, 8'd4, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5,
        8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd6, 8'd6, 8'd6,
        8'd6, 8'd6, 8'd6, 8'd6, 8'd6, 8'd7, 8'd7, 8'd7,
        8'd7, 8'd7, 8'd7, 8'd7, 8'd8, 8'd8, 8'd8, 8'd8,
        8'd8, 8'd8, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9,
        8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd11, 8'd11, 8'd11,
        8'd11, 8'd11, 8'd12, 8'd12, 8'd12, 8'd12, 8'd12, 8'd13,
        8'd13, 8'd13, 8'd13, 8'd14, 8'd14, 8'd14, 8'd14, 8'd15,
        8'd15, 8'd15, 8'd16, 8'd16, 8'd16, 8'd16, 8'd17, 8'd17,
        8'd17, 8'd18, 8'd18, 8'd18, 8'd19, 8'd19, 8'd19, 8'd20,
        8'd20, 8'd20, 8'd21, 8'd21, 8'd22, 8'd22, 8'd22, 8'd23,
        8'd23, 8'd24, 8'd24, 8'd25, 8'd25, 8'd25, 8'd26, 8'd26,
        8'd27, 8'd27, 8'd28, 8'd28, 8'd29, 8'd29, 8'd30, 8'd30,
        8'd31, 8'd32, 8'd32, 8'd33, 8'd33, 8'd34, 8'd35, 8'd35,
        8'd36, 8'd36, 8'd37, 8'd38, 8'd38, 8'd39, 8'd40, 8'd40,
        8'd41, 8'd42, 8'd43, 8'd43, 8'd44, 8'd45, 8'd46, 8'd47,
        8'd48, 8'd48, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54,
        8'd55, 8'd56, 8'd57, 8'd58, 8'd59, 8'd60, 8'd61, 8'd62,
        8'd63, 8'd64, 8'd65, 8'd66, 8'd68, 8'd69, 8'd70, 8'd71,
        8'd73, 8'd74, 8'd75, 8'd76, 8'd78, 8'd79, 8'd81, 8'd82,
        8'd83, 8'd85, 8'd86, 8'd88, 8'd90, 8'd91, 8'd93, 8'd94,
        8'd96, 8'd98, 8'd99, 8'd101, 8'd103, 8'd105, 8'd107, 8'd109,
        8'd110, 8'd112, 8'd114, 8'd116, 8'd118, 8'd121, 8'd123, 8'd125,
        8'd127, 8'd129, 8'd132, 8'd134, 8'd136, 8'd139, 8'd141, 8'd144,
        8'd146, 8'd149, 8'd151, 8'd154, 8'd157, 8'd159, 8'd162, 8'd165,
        8'd168, 8'd171, 8'd174, 8'd177, 8'd180, 8'd183, 8'd186, 8'd190,
        8'd193, 8'd196, 8'd200, 8'd203, 8'd207, 8'd211, 8'd214, 8'd218,
        8'd222, 8'd226, 8'd230, 8'd234, 8'd238, 8'd242, 8'd248, 8'd255
    };

endpackage

`default_nettype wire

// ----- rtl/hsv_to_rgb_dimmed_grb.sv -----
// Each item passes the front, ramp and mix stage registers in order, and its result then strobes.
// Throughput: one item per cycle; busy is always low, since the pipeline never holds.
// Both table look-ups share the front stage; the base, span and reciprocal multiplies get a stage each.
// Reset clears the valid bits and sets the attenuation shift to zero; items in flight are lost.
// Top level: HSV pixel in, dimmed and attenuated RGB with packed GRB word out.
`default_nettype none

module hsv_to_rgb_dimmed_grb (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire hsv2rgb_pkg::pixel_t pixel,
    input  wire logic                atten_we,
    input  wire logic [2:0]          atten_data,
    output logic                     result_strobe,
    output hsv2rgb_pkg::result_t     result
);
    import hsv2rgb_pkg::*;

    logic accept;
    logic s1_valid;
    logic s4_valid;
    s1_t  s1_stage;
    s4_t  s4_stage;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    hsv2rgb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_pixel  (pixel),
        .out_valid (s1_valid),
        .out_stage (s1_stage)
    );

    hsv2rgb_ramp u_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_stage  (s1_stage),
        .out_valid (s4_valid),
        .out_stage (s4_stage)
    );

    hsv2rgb_mix u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .atten_we   (atten_we),
        .atten_data (atten_data),
        .in_valid   (s4_valid),
        .in_stage   (s4_stage),
        .out_valid  (result_strobe),
        .out_result (result)
    );

endmodule

`default_nettype wire

// ----- rtl/hsv2rgb_front.sv -----
// First pipeline stage: hue wrap, sector split and dim-curve look-ups.
`default_nettype none

module hsv2rgb_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire hsv2rgb_pkg::pixel_t in_pixel,
    output logic                     out_valid,
    output hsv2rgb_pkg::s1_t         out_stage
);
    import hsv2rgb_pkg::*;

    logic [8:0] hue_w;
    logic [5:0] rem;
    sector_t    sector;
    logic [7:0] dim_sat;
    logic       valid_reg;
    s1_t        stage_next;
    s1_t        stage_reg;

    always_comb
    begin
        hue_w = (in_pixel.hue >= HUE_FULL) ? (in_pixel.hue - HUE_FULL) : in_pixel.hue;

        priority if (hue_w >= 9'd300)
        begin
            sector = SEC_MAGENTA_RED;
            rem    = 6'(hue_w - 9'd300);
        end
        else if (hue_w >= 9'd240)
        begin
            sector = SEC_BLUE_MAGENTA;
            rem    = 6'(hue_w - 9'd240);
        end
        else if (hue_w >= 9'd180)
        begin
            sector = SEC_CYAN_BLUE;
            rem    = 6'(hue_w - 9'd180);
        end
        else if (hue_w >= 9'd120)
        begin
            sector = SEC_GREEN_CYAN;
            rem    = 6'(hue_w - 9'd120);
        end
        else if (hue_w >= 9'd60)
        begin
            sector = SEC_YELLOW_GREEN;
            rem    = 6'(hue_w - 9'd60);
        end
        else
        begin
            sector = SEC_RED_YELLOW;
            rem    = hue_w[5:0];
        end

        dim_sat = PERC_LUT[~in_pixel.saturation];

        stage_next.led_index = in_pixel.led_index;
        stage_next.sector    = sector;
        // Only a saturation of zero maps to the top of the curve.
        stage_next.grey      = (dim_sat == 8'hFF);
        // Odd sectors ramp downwards, so their fraction runs backwards.
        stage_next.frac      = sector[0] ? (SECTOR_SPAN - rem) : rem;
        stage_next.val       = PERC_LUT[in_pixel.brightness];
        stage_next.dim_sat   = dim_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

`default_nettype wire

// ----- rtl/hsv2rgb_ramp.sv -----
// Middle pipeline stages: base level, span times fraction, and the divide by 60.
`default_nettype none

module hsv2rgb_ramp (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire hsv2rgb_pkg::s1_t in_stage,
    output logic                  out_valid,
    output hsv2rgb_pkg::s4_t      out_stage
);
    import hsv2rgb_pkg::*;

    logic [15:0] lo_prod;
    logic [7:0]  span;
    logic [11:0] quarter;
    logic [24:0] recip_prod;
    logic [2:0]  valid_reg;
    s2_t         s2_next;
    s2_t         s2_reg;
    s3_t         s3_next;
    s3_t         s3_reg;
    s4_t         s4_next;
    s4_t         s4_reg;

    always_comb
    begin
        lo_prod           = {8'd0, in_stage.dim_sat} * {8'd0, in_stage.val};
        s2_next.led_index = in_stage.led_index;
        s2_next.sector    = in_stage.sector;
        s2_next.grey      = in_stage.grey;
        s2_next.frac      = in_stage.frac;
        s2_next.val       = in_stage.val;
        s2_next.lo        = lo_prod[15:8];

        // The base never exceeds the value, so the span cannot go negative.
        span              = s2_reg.val - s2_reg.lo;
        s3_next.led_index = s2_reg.led_index;
        s3_next.sector    = s2_reg.sector;
        s3_next.grey      = s2_reg.grey;
        s3_next.prod      = {6'd0, span} * {8'd0, s2_reg.frac};
        s3_next.val       = s2_reg.val;
        s3_next.lo        = s2_reg.lo;

        // Divide by 60 as a divide by 4 followed by a reciprocal multiply for 15.
        quarter           = s3_reg.prod[13:2];
        recip_prod        = {13'd0, quarter} * {12'd0, RECIP_15};
        s4_next.led_index = s3_reg.led_index;
        s4_next.sector    = s3_reg.sector;
        s4_next.grey      = s3_reg.grey;
        s4_next.ramp      = recip_prod[23:16] + s3_reg.lo;
        s4_next.val       = s3_reg.val;
        s4_next.lo        = s3_reg.lo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 3'b000;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s2_reg <= s2_next;
        end
        if (valid_reg[0])
        begin
            s3_reg <= s3_next;
        end
        if (valid_reg[1])
        begin
            s4_reg <= s4_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_stage = s4_reg;

endmodule

`default_nettype wire

// ----- rtl/hsv2rgb_mix.sv -----
// Last pipeline stage: channel selection by sector, attenuation and word packing.
`default_nettype none

module hsv2rgb_mix (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             atten_we,
    input  wire logic [2:0]       atten_data,
    input  wire logic             in_valid,
    input  wire hsv2rgb_pkg::s4_t in_stage,
    output logic                  out_valid,
    output hsv2rgb_pkg::result_t  out_result
);
    import hsv2rgb_pkg::*;

    logic [2:0] atten_reg;
    logic       valid_reg;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    result_t    result_next;
    result_t    result_reg;

    always_comb
    begin
        if (in_stage.grey)
        begin
            r = in_stage.val;
            g = in_stage.val;
            b = in_stage.val;
        end
        else
        begin
            unique case (in_stage.sector)
                SEC_RED_YELLOW:
                begin
                    r = in_stage.val;
                    g = in_stage.ramp;
                    b = in_stage.lo;
                end
                SEC_YELLOW_GREEN:
                begin
                    r = in_stage.ramp;
                    g = in_stage.val;
                    b = in_stage.lo;
                end
                SEC_GREEN_CYAN:
                begin
                    r = in_stage.lo;
                    g = in_stage.val;
                    b = in_stage.ramp;
                end
                SEC_CYAN_BLUE:
                begin
                    r = in_stage.lo;
                    g = in_stage.ramp;
                    b = in_stage.val;
                end
                SEC_BLUE_MAGENTA:
                begin
                    r = in_stage.ramp;
                    g = in_stage.lo;
                    b = in_stage.val;
                end
                default:
                begin
                    r = in_stage.val;
                    g = in_stage.lo;
                    b = in_stage.ramp;
                end
            endcase
        end

        result_next.led_number = in_stage.led_index;
        result_next.red        = r >> atten_reg;
        result_next.green      = g >> atten_reg;
        result_next.blue       = b >> atten_reg;
        result_next.grb_word   = {g >> atten_reg, r >> atten_reg, b >> atten_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atten_reg <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (atten_we)
            begin
                atten_reg <= atten_data;
            end
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire
